@@ src/bal_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_pkg
// shared widths, command and status codes, and controller command bundle
// for the bounded array list core
// ----------------------------------------------------------------------------
package bal_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int IDX_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int POS_W      = 5;
	localparam int CMD_W      = 4;
	localparam int DATA_W     = 32;
	localparam int STS_W      = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_HEAD  = 4'd0,
		CMD_INS_TAIL  = 4'd1,
		CMD_INS_AT    = 4'd2,
		CMD_REM_HEAD  = 4'd3,
		CMD_REM_TAIL  = 4'd4,
		CMD_REM_AT    = 4'd5,
		CMD_REM_VALUE = 4'd6,
		CMD_READ      = 4'd7,
		CMD_FIND      = 4'd8
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK        = 3'd0,
		STS_FULL      = 3'd1,
		STS_EMPTY     = 3'd2,
		STS_BAD_POS   = 3'd3,
		STS_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_MATCH = 2'd1,
		ST_EXEC  = 2'd2
	} state_t;

	typedef struct packed {
		logic load;
		logic match;
		logic exec;
	} ctrl_cmd_t;

endpackage

@@ src/bal_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_ctrl
// sequencer for one command: capture, match scan, execute into output register
// ----------------------------------------------------------------------------
module bal_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output bal_pkg::ctrl_cmd_t ctl
);
	import bal_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		in_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_MATCH;
				end
			end
			ST_MATCH: begin
				ctl.match = 1'b1;
				state_d   = ST_EXEC;
			end
			ST_EXEC: begin
				// wait here until the output register can take the result
				if (out_free) begin
					ctl.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ src/bal_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_datapath
// entry registers, count, match vector, shift network and result registers
// ----------------------------------------------------------------------------
module bal_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bal_pkg::ctrl_cmd_t                ctl,
	input  logic [bal_pkg::CMD_W-1:0]         cmd,
	input  logic [bal_pkg::POS_W-1:0]         position,
	input  logic signed [bal_pkg::DATA_W-1:0] value,
	output logic [bal_pkg::STS_W-1:0]         status,
	output logic signed [bal_pkg::DATA_W-1:0] read_data,
	output logic [bal_pkg::IDX_W-1:0]         found_index,
	output logic [bal_pkg::CNT_W-1:0]         entry_count
);
	import bal_pkg::*;

	logic [CMD_W-1:0]  cmd_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] entries_q [LIST_DEPTH];
	logic [DATA_W-1:0] entries_d [LIST_DEPTH];
	logic [LIST_DEPTH-1:0] match_q;

	logic [STS_W-1:0]  status_q;
	logic [DATA_W-1:0] data_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  count_out_q;

	logic              full, empty, hit, do_ins, do_rem;
	logic [IDX_W-1:0]  hit_idx, at;
	logic [CNT_W-1:0]  last;
	status_t           sts_d;
	logic [DATA_W-1:0] data_d;
	logic [IDX_W-1:0]  idx_d;
	logic [CNT_W-1:0]  count_d;

	// command capture, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			pos_q <= position;
			val_q <= value;
		end
	end

	// compare every live entry against the value
	always_ff @(posedge clk) begin
		if (ctl.match) begin
			for (int i = 0; i < LIST_DEPTH; i++) begin
				match_q[i] <= (entries_q[i] == val_q) && (CNT_W'(i) < count_q);
			end
		end
	end

	// lowest matching index
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign full  = (count_q == CNT_W'(LIST_DEPTH));
	assign empty = (count_q == '0);
	assign last  = count_q - CNT_W'(1);

	always_comb begin
		sts_d   = STS_OK;
		data_d  = '0;
		idx_d   = '0;
		count_d = count_q;
		do_ins  = 1'b0;
		do_rem  = 1'b0;
		at      = '0;
		case (cmd_q)
			CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
				if (full) begin
					sts_d = STS_FULL;
				end else if (cmd_q == CMD_INS_AT && pos_q > count_q) begin
					sts_d = STS_BAD_POS;
				end else begin
					do_ins  = 1'b1;
					count_d = count_q + CNT_W'(1);
					if (cmd_q == CMD_INS_HEAD) begin
						at = '0;
					end else if (cmd_q == CMD_INS_TAIL) begin
						at = count_q[IDX_W-1:0];
					end else begin
						at = pos_q[IDX_W-1:0];
					end
				end
			end
			CMD_REM_HEAD, CMD_REM_TAIL, CMD_REM_AT, CMD_REM_VALUE, CMD_READ,
			CMD_FIND: begin
				if (empty) begin
					sts_d = STS_EMPTY;
				end else if (cmd_q == CMD_REM_HEAD) begin
					do_rem = 1'b1;
					at     = '0;
				end else if (cmd_q == CMD_REM_TAIL) begin
					do_rem = 1'b1;
					at     = last[IDX_W-1:0];
				end else if (cmd_q == CMD_REM_AT || cmd_q == CMD_READ) begin
					if (pos_q >= count_q) begin
						sts_d = STS_BAD_POS;
					end else if (cmd_q == CMD_REM_AT) begin
						do_rem = 1'b1;
						at     = pos_q[IDX_W-1:0];
					end else begin
						data_d = entries_q[pos_q[IDX_W-1:0]];
					end
				end else if (!hit) begin
					sts_d = STS_NOT_FOUND;
				end else if (cmd_q == CMD_REM_VALUE) begin
					do_rem = 1'b1;
					at     = hit_idx;
				end else begin
					idx_d = hit_idx;
				end
				if (do_rem) begin
					count_d = last;
				end
			end
			default: begin
				sts_d = STS_OK;
			end
		endcase
	end

	// shift network: open a gap at 'at' or close the one there
	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			entries_d[i] = entries_q[i];
		end
		if (do_ins) begin
			if (at == '0) begin
				entries_d[0] = val_q;
			end
			for (int i = 1; i < LIST_DEPTH; i++) begin
				if (IDX_W'(i) == at) begin
					entries_d[i] = val_q;
				end else if (IDX_W'(i) > at) begin
					entries_d[i] = entries_q[i-1];
				end
			end
		end else if (do_rem) begin
			for (int i = 0; i < LIST_DEPTH - 1; i++) begin
				if (IDX_W'(i) >= at) begin
					entries_d[i] = entries_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			for (int i = 0; i < LIST_DEPTH; i++) begin
				entries_q[i] <= entries_d[i];
			end
			status_q    <= sts_d;
			data_q      <= data_d;
			idx_q       <= idx_d;
			count_out_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.exec) begin
			count_q <= count_d;
		end
	end

	assign status      = status_q;
	assign read_data   = data_q;
	assign found_index = idx_q;
	assign entry_count = count_out_q;

endmodule

@@ src/bounded_array_list_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_core
// ordered list of up to 16 signed 32-bit values with insert, remove, read
// and find commands, one result transaction per command
// ----------------------------------------------------------------------------
// Each command goes from acceptance to result in steps: capture the command,
// compare all sixteen entry registers against the value into a match vector,
// then pick the first match and shift the entries. The controller walks these
// steps for one command at a time, so the input side takes no new command
// until the current one has executed. The result sits
// in an output register; the next command is accepted and scanned while it
// waits, and the execute step holds until that register is free. Entries
// are not reset; count resets to zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module bounded_array_list_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// command channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bal_pkg::CMD_W-1:0]         cmd,
	input  logic [bal_pkg::POS_W-1:0]         position,
	input  logic signed [bal_pkg::DATA_W-1:0] value,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bal_pkg::STS_W-1:0]         status,
	output logic signed [bal_pkg::DATA_W-1:0] read_data,
	output logic [bal_pkg::IDX_W-1:0]         found_index,
	output logic [bal_pkg::CNT_W-1:0]         entry_count
);
	import bal_pkg::*;

	// command strobes from the sequencer to the datapath
	ctrl_cmd_t ctl;

	bal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl)
	);

	// entries, count, shift network and result register
	bal_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cmd         (cmd),
		.position    (position),
		.value       (value),
		.status      (status),
		.read_data   (read_data),
		.found_index (found_index),
		.entry_count (entry_count)
	);

	// count never exceeds capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count <= CNT_W'(LIST_DEPTH)))
		else $error("entry count above capacity");

	// full status only with a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STS_FULL) |-> (entry_count == CNT_W'(LIST_DEPTH)))
		else $error("full status with list not full");

	// empty status only with an empty list
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STS_EMPTY) |-> (entry_count == '0))
		else $error("empty status with entries present");

	// data and index are zero unless the command succeeded
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STS_OK) |-> (read_data == '0 && found_index == '0))
		else $error("nonzero data or index on failed command");

	// a command enters only while the sequencer is idle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("command accepted while another is in flight");

endmodule
